>>> hdl/additive_pixel_blender_core_macros.svh
// Assertion helpers used by the blender core.
`ifndef ADDITIVE_PIXEL_BLENDER_CORE_MACROS_SVH
`define ADDITIVE_PIXEL_BLENDER_CORE_MACROS_SVH

// Check post in the same cycle as pre.
`define APB_ASSERT_NOW(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("apb assertion failed");

// Check post in the cycle after pre.
`define APB_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("apb assertion failed");

`endif

>>> hdl/apb_pkg.sv
`timescale 1ns / 1ps

package apb_pkg;

    localparam int SHIFT_W    = 5;
    localparam int LOSS_W     = 3;
    localparam int CHAN_W     = 8;
    localparam int LEVEL_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam int WORD_W     = 32;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [LOSS_W-1:0]  loss;
    } t_chan_cfg;

    localparam t_cfg_idx CFG_RED_SHIFT   = 3'd0;
    localparam t_cfg_idx CFG_RED_LOSS    = 3'd1;
    localparam t_cfg_idx CFG_GREEN_SHIFT = 3'd2;
    localparam t_cfg_idx CFG_GREEN_LOSS  = 3'd3;
    localparam t_cfg_idx CFG_BLUE_SHIFT  = 3'd4;
    localparam t_cfg_idx CFG_BLUE_LOSS   = 3'd5;

    localparam t_chan_cfg RED_CFG_RST   = '{shift: 5'd16, loss: 3'd0};
    localparam t_chan_cfg GREEN_CFG_RST = '{shift: 5'd8,  loss: 3'd0};
    localparam t_chan_cfg BLUE_CFG_RST  = '{shift: 5'd0,  loss: 3'd0};

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

endpackage

>>> hdl/apb_chan.sv
`timescale 1ns / 1ps

// One color channel: unpack both words, weight the source (unless i_full),
// add with saturation and repack into the destination format.
module apb_chan
    import apb_pkg::*;
#(
    parameter int PIXEL_BITS = 32
) (
    input  logic [PIXEL_BITS-1:0] i_src,
    input  logic [PIXEL_BITS-1:0] i_dst,
    input  t_chan_cfg             i_cfg,
    input  logic                  i_full,
    input  logic [LEVEL_W-1:0]    i_level,
    output logic [PIXEL_BITS-1:0] o_packed
);

    logic [PIXEL_BITS-1:0]       src_sh;
    logic [PIXEL_BITS-1:0]       dst_sh;
    logic [CHAN_W-1:0]           fmask;
    logic [CHAN_W-1:0]           s8;
    logic [CHAN_W-1:0]           d8;
    logic [CHAN_W+LEVEL_W-1:0]   prod;
    logic [CHAN_W-1:0]           add8;
    logic [CHAN_W:0]             sum9;
    logic [CHAN_W-1:0]           v8;
    logic [CHAN_W-1:0]           v_cut;
    logic [PIXEL_BITS-1:0]       v_ext;

    always_comb begin
        src_sh = i_src >> i_cfg.shift;
        dst_sh = i_dst >> i_cfg.shift;
        fmask  = CHAN_MAX >> i_cfg.loss;
        // widen the field back to 8 bits
        s8     = (src_sh[CHAN_W-1:0] & fmask) << i_cfg.loss;
        d8     = (dst_sh[CHAN_W-1:0] & fmask) << i_cfg.loss;
        prod   = {{LEVEL_W{1'b0}}, s8} * {{CHAN_W{1'b0}}, i_level};
        add8   = i_full ? s8 : prod[CHAN_W+LEVEL_W-1:LEVEL_W];
        sum9   = {1'b0, d8} + {1'b0, add8};
        v8     = sum9[CHAN_W] ? CHAN_MAX : sum9[CHAN_W-1:0];
        v_cut  = v8 >> i_cfg.loss;
        v_ext  = PIXEL_BITS'(v_cut);
    end

    assign o_packed = v_ext << i_cfg.shift;

endmodule

>>> hdl/additive_pixel_blender_core.sv
`timescale 1ns / 1ps

// Channel   Ports                                         Handshake
// input     i_source_word i_dest_word i_blend_alpha       i_start & !o_busy
//           i_unscaled
// result    o_result_word o_write_enable                  o_done, one cycle
// config    i_cfg_idx i_cfg_wdata                         i_cfg_we
//
// One item per cycle; each result passes through the input register and then
// the result register, around the blend logic.
// o_busy is always low: every start is taken.
// Reset is synchronous, active low, and restores the default 8-8-8 layout.
// The receiver cannot stall; each result is shown for exactly one cycle.
module additive_pixel_blender_core
    import apb_pkg::*;
#(
    parameter int PIXEL_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [WORD_W-1:0]     i_source_word,
    input  logic [WORD_W-1:0]     i_dest_word,
    input  logic [CHAN_W-1:0]     i_blend_alpha,
    input  logic                  i_unscaled,
    output logic                  o_done,
    output logic [WORD_W-1:0]     o_result_word,
    output logic                  o_write_enable,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

`include "additive_pixel_blender_core_macros.svh"

    t_chan_cfg r_red_cfg;
    t_chan_cfg r_green_cfg;
    t_chan_cfg r_blue_cfg;

    logic                  r_in_valid;
    logic [PIXEL_BITS-1:0] r_src;
    logic [PIXEL_BITS-1:0] r_dst;
    logic [LEVEL_W-1:0]    r_level;
    logic                  r_full;

    logic                  r_out_valid;
    logic [PIXEL_BITS-1:0] r_res;
    logic                  r_we;

    logic [PIXEL_BITS-1:0] red_pk;
    logic [PIXEL_BITS-1:0] green_pk;
    logic [PIXEL_BITS-1:0] blue_pk;
    logic                  n_we;
    logic [PIXEL_BITS-1:0] n_res;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_cfg   <= RED_CFG_RST;
            r_green_cfg <= GREEN_CFG_RST;
            r_blue_cfg  <= BLUE_CFG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RED_SHIFT:   r_red_cfg.shift   <= i_cfg_wdata[SHIFT_W-1:0];
                CFG_RED_LOSS:    r_red_cfg.loss    <= i_cfg_wdata[LOSS_W-1:0];
                CFG_GREEN_SHIFT: r_green_cfg.shift <= i_cfg_wdata[SHIFT_W-1:0];
                CFG_GREEN_LOSS:  r_green_cfg.loss  <= i_cfg_wdata[LOSS_W-1:0];
                CFG_BLUE_SHIFT:  r_blue_cfg.shift  <= i_cfg_wdata[SHIFT_W-1:0];
                CFG_BLUE_LOSS:   r_blue_cfg.loss   <= i_cfg_wdata[LOSS_W-1:0];
                default: begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    // input register: words are cut to the pixel width here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src   <= i_source_word[PIXEL_BITS-1:0];
        r_dst   <= i_dest_word[PIXEL_BITS-1:0];
        r_level <= i_blend_alpha[CHAN_W-1:CHAN_W-LEVEL_W];
        r_full  <= i_unscaled;
    end

    apb_chan #(.PIXEL_BITS(PIXEL_BITS)) u_red (
        .i_src    (r_src),
        .i_dst    (r_dst),
        .i_cfg    (r_red_cfg),
        .i_full   (r_full),
        .i_level  (r_level),
        .o_packed (red_pk)
    );

    apb_chan #(.PIXEL_BITS(PIXEL_BITS)) u_green (
        .i_src    (r_src),
        .i_dst    (r_dst),
        .i_cfg    (r_green_cfg),
        .i_full   (r_full),
        .i_level  (r_level),
        .o_packed (green_pk)
    );

    apb_chan #(.PIXEL_BITS(PIXEL_BITS)) u_blue (
        .i_src    (r_src),
        .i_dst    (r_dst),
        .i_cfg    (r_blue_cfg),
        .i_full   (r_full),
        .i_level  (r_level),
        .o_packed (blue_pk)
    );

    always_comb begin
        // transparent source, or zero level when not unscaled: keep the destination
        n_we  = (r_src != '0) && (r_full || (r_level != '0));
        n_res = n_we ? (red_pk | green_pk | blue_pk) : r_dst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_we  <= n_we;
    end

    assign o_done         = r_out_valid;
    assign o_result_word  = WORD_W'(r_res);
    assign o_write_enable = r_we;

    `APB_ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, r_in_valid, o_done)
    `APB_ASSERT_NEXT(a_keep_dest, i_clk, i_rst_n, r_in_valid && !n_we, o_result_word == WORD_W'($past(r_dst)))
    `APB_ASSERT_NEXT(a_clear_no_write, i_clk, i_rst_n, r_in_valid && (r_src == '0), !o_write_enable)
    `APB_ASSERT_NOW(a_upper_zero, i_clk, i_rst_n, o_done, (o_result_word >> PIXEL_BITS) == '0)

endmodule
